@@ src/uffv_pkg.sv @@
`timescale 1ns / 1ps

package uffv_pkg;

    // Default width of the saturating byte counter
    localparam int COUNT_BITS_DEF = 28;

    // Configuration register widths and reset values
    localparam int COMP_W = 27;
    localparam int FILE_W = 28;
    localparam logic [COMP_W-1:0] MAX_COMP_RESET = COMP_W'(16 * 1024 * 1024);
    localparam logic [FILE_W-1:0] MAX_FILE_RESET = FILE_W'(64 * 1024 * 1024);

    // Register indexes (byte address bit 2)
    localparam logic REG_MAX_COMP = 1'b0;
    localparam logic REG_MAX_FILE = 1'b1;

    // Format codes
    localparam logic [2:0] FMT_INVALID = 3'd0;
    localparam logic [2:0] FMT_V1      = 3'd1;
    localparam logic [2:0] FMT_V2      = 3'd2;
    localparam logic [2:0] FMT_V3      = 3'd3;
    localparam logic [2:0] FMT_V4      = 3'd4;
    localparam logic [2:0] FMT_V5      = 3'd5;

    // "PQCUSR05" read as a little-endian 64-bit word
    localparam logic [63:0] V5_MAGIC_LE = 64'h3530_5253_5543_5150;
    localparam logic [31:0] V5_VERSION  = 32'd5;
    localparam logic [31:0] V5_COUNT    = 32'd9;

    // Legacy version words
    localparam logic [31:0] VER_V2 = 32'd2;
    localparam logic [31:0] VER_V3 = 32'd3;
    localparam logic [31:0] VER_V4 = 32'd4;

    // Component counts per layout
    localparam logic [3:0] PARTS_9 = 4'd9;
    localparam logic [3:0] PARTS_7 = 4'd7;
    localparam logic [3:0] PARTS_4 = 4'd4;

    // Field byte positions
    localparam logic [4:0] SH_HALF      = 5'd4;
    localparam logic [4:0] SH_LEN_END   = 5'd8;
    localparam logic [4:0] SH_VER_END   = 5'd4;
    localparam logic [4:0] SH_TOTAL_END = 5'd12;
    localparam logic [4:0] SH_HDR_END   = 5'd16;
    localparam logic [2:0] HEAD_LAST    = 3'd7;

endpackage

@@ src/user_file_format_validator.sv @@
`timescale 1ns / 1ps

// Channel   Direction  Handshake                 Payload
// input     in         i_valid / o_stall         i_data_byte[7:0], i_last
// result    out        o_valid / i_stall         o_valid_res, o_format[2:0]
// config    in         psel/penable/pwrite/pready paddr[2:0], pwdata[31:0], prdata[31:0]
//
// One byte word per cycle unless a stalled result holds back a last word; the parse state
// takes one byte per cycle through a single update of the header/length/body tracker.
// The verdict is registered: the word flagged last is held in the input register,
// then its verdict is loaded into the result register.
// Synchronous active-low reset clears the parse state and loads register defaults.
// A stalled result holds; bytes keep flowing until the input register holds a
// last word that finds the result register still full.

module user_file_format_validator #(
    parameter int COUNT_BITS = uffv_pkg::COUNT_BITS_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,

    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last,

    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_valid_res,
    output logic [2:0]  o_format,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int CmpW = (COUNT_BITS > uffv_pkg::FILE_W) ? COUNT_BITS : uffv_pkg::FILE_W;
    localparam logic [COUNT_BITS-1:0] CntMax = '1;

    typedef enum logic [2:0] {
        PH_HEAD,
        PH_V5HDR,
        PH_LEN,
        PH_BODY,
        PH_DONE
    } t_phase;

    // Configuration
    logic [uffv_pkg::COMP_W-1:0] r_max_comp;
    logic [uffv_pkg::FILE_W-1:0] r_max_file;

    // Input register
    logic       r_in_vld;
    logic [7:0] r_in_byte;
    logic       r_in_last;

    // Per-file parse state
    logic [COUNT_BITS-1:0]       r_count,   n_count;
    t_phase                      r_phase,   n_phase;
    logic [63:0]                 r_head,    n_head;
    logic [4:0]                  r_shift,   n_shift;
    logic [uffv_pkg::COMP_W-1:0] r_body,    n_body;
    logic [3:0]                  r_parts,   n_parts;
    logic [2:0]                  r_kind,    n_kind;
    logic [COUNT_BITS-1:0]       r_decl_lo, n_decl_lo;
    logic                        r_decl_hi, n_decl_hi;
    logic                        r_failed,  n_failed;

    // Result register
    logic       r_out_vld;
    logic       r_out_res, n_out_res;
    logic [2:0] r_out_fmt, n_out_fmt;

    logic        out_free;
    logic        proc_go;
    logic        in_free;
    logic        cnt_sat;
    logic        fail_now;
    logic        parse_fail;
    logic        len_take;
    logic        len_bad;
    logic [63:0] len_val;
    logic [63:0] asm_word;
    logic [4:0]  sh_inc;
    logic [26:0] body_dec;
    logic [3:0]  parts_dec;
    logic        cfg_wr;

    assign out_free = !r_out_vld || !i_stall;
    assign proc_go  = r_in_vld && (!r_in_last || out_free);
    assign in_free  = !r_in_vld || proc_go;
    assign o_stall  = !in_free;

    assign o_valid     = r_out_vld;
    assign o_valid_res = r_out_res;
    assign o_format    = r_out_fmt;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;

    always_comb begin
        unique case (paddr[2])
            uffv_pkg::REG_MAX_COMP: prdata = {5'd0, r_max_comp};
            uffv_pkg::REG_MAX_FILE: prdata = {4'd0, r_max_file};
            default:                prdata = '0;
        endcase
    end

    // Byte count and file-level checks
    assign cnt_sat  = (r_count == CntMax);
    assign n_count  = cnt_sat ? r_count : r_count + 1'b1;
    assign fail_now = r_failed || cnt_sat || (CmpW'(n_count) > CmpW'(r_max_file));

    assign sh_inc    = r_shift + 1'b1;
    assign body_dec  = (r_body != '0) ? r_body - 1'b1 : r_body;
    assign parts_dec = (r_parts != '0) ? r_parts - 1'b1 : r_parts;

    // Parse one byte
    always_comb begin
        n_phase    = r_phase;
        n_head     = r_head;
        n_shift    = r_shift;
        n_body     = r_body;
        n_parts    = r_parts;
        n_kind     = r_kind;
        n_decl_lo  = r_decl_lo;
        n_decl_hi  = r_decl_hi;
        parse_fail = 1'b0;
        len_take   = 1'b0;
        len_val    = '0;
        asm_word   = '0;
        len_bad    = 1'b0;

        if (!fail_now) begin
            unique case (r_phase)
                PH_HEAD: begin
                    asm_word = r_head | (64'(r_in_byte) << {r_count[2:0], 3'b000});
                    n_head   = asm_word;
                    if (r_count[2:0] == uffv_pkg::HEAD_LAST) begin
                        if (asm_word == uffv_pkg::V5_MAGIC_LE) begin
                            n_kind  = uffv_pkg::FMT_V5;
                            n_head  = '0;
                            n_shift = '0;
                            n_phase = PH_V5HDR;
                        end else if (asm_word[31:0] == uffv_pkg::VER_V3 ||
                                     asm_word[31:0] == uffv_pkg::VER_V4 ||
                                     asm_word[31:0] == uffv_pkg::VER_V2) begin
                            if (asm_word[31:0] == uffv_pkg::VER_V3) begin
                                n_kind  = uffv_pkg::FMT_V3;
                                n_parts = uffv_pkg::PARTS_9;
                            end else if (asm_word[31:0] == uffv_pkg::VER_V4) begin
                                n_kind  = uffv_pkg::FMT_V4;
                                n_parts = uffv_pkg::PARTS_9;
                            end else begin
                                n_kind  = uffv_pkg::FMT_V2;
                                n_parts = uffv_pkg::PARTS_7;
                            end
                            // upper word already holds the low half of the first length
                            n_head  = {32'd0, asm_word[63:32]};
                            n_shift = uffv_pkg::SH_HALF;
                            n_phase = PH_LEN;
                        end else begin
                            n_kind   = uffv_pkg::FMT_V1;
                            n_parts  = uffv_pkg::PARTS_4;
                            len_take = 1'b1;
                            len_val  = asm_word;
                        end
                    end
                end
                PH_V5HDR: begin
                    asm_word = {r_head[55:0], r_in_byte};
                    n_head   = asm_word;
                    n_shift  = sh_inc;
                    if (sh_inc == uffv_pkg::SH_VER_END) begin
                        parse_fail = (asm_word != 64'(uffv_pkg::V5_VERSION));
                        n_head     = '0;
                    end else if (sh_inc == uffv_pkg::SH_TOTAL_END) begin
                        n_decl_lo = asm_word[COUNT_BITS-1:0];
                        n_decl_hi = |asm_word[63:COUNT_BITS];
                        n_head    = '0;
                    end else if (sh_inc >= uffv_pkg::SH_HDR_END) begin
                        parse_fail = (asm_word != 64'(uffv_pkg::V5_COUNT));
                        n_head     = '0;
                        n_shift    = '0;
                        n_parts    = uffv_pkg::PARTS_9;
                        n_phase    = PH_LEN;
                    end
                end
                PH_LEN: begin
                    if (r_kind == uffv_pkg::FMT_V5) begin
                        asm_word = {r_head[55:0], r_in_byte};
                    end else begin
                        asm_word = r_head | (64'(r_in_byte) << {r_shift[2:0], 3'b000});
                    end
                    n_head  = asm_word;
                    n_shift = sh_inc;
                    if (sh_inc >= uffv_pkg::SH_LEN_END) begin
                        len_take = 1'b1;
                        len_val  = asm_word;
                    end
                end
                PH_BODY: begin
                    n_body = body_dec;
                    if (body_dec == '0) begin
                        n_parts = parts_dec;
                        if (parts_dec == '0) begin
                            n_phase = PH_DONE;
                        end else begin
                            n_head  = '0;
                            n_shift = '0;
                            n_phase = PH_LEN;
                        end
                    end
                end
                default: begin
                    // any byte past the last body
                    parse_fail = 1'b1;
                end
            endcase

            if (len_take) begin
                len_bad = (len_val[63:uffv_pkg::COMP_W] != '0) ||
                          (len_val[uffv_pkg::COMP_W-1:0] == '0) ||
                          (len_val[uffv_pkg::COMP_W-1:0] > r_max_comp);
                if (len_bad) begin
                    parse_fail = 1'b1;
                end else begin
                    n_body  = len_val[uffv_pkg::COMP_W-1:0];
                    n_phase = PH_BODY;
                end
            end
        end

        n_failed  = fail_now || parse_fail;
        n_out_res = !n_failed && (n_phase == PH_DONE) &&
                    (n_kind != uffv_pkg::FMT_V5 || (!n_decl_hi && n_decl_lo == n_count));
        n_out_fmt = n_out_res ? n_kind : uffv_pkg::FMT_INVALID;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_comp <= uffv_pkg::MAX_COMP_RESET;
            r_max_file <= uffv_pkg::MAX_FILE_RESET;
            r_in_vld   <= 1'b0;
            r_out_vld  <= 1'b0;
            r_count    <= '0;
            r_phase    <= PH_HEAD;
            r_head     <= '0;
            r_shift    <= '0;
            r_body     <= '0;
            r_parts    <= '0;
            r_kind     <= uffv_pkg::FMT_INVALID;
            r_decl_lo  <= '0;
            r_decl_hi  <= 1'b0;
            r_failed   <= 1'b0;
        end else begin
            if (cfg_wr) begin
                unique case (paddr[2])
                    uffv_pkg::REG_MAX_COMP: r_max_comp <= pwdata[uffv_pkg::COMP_W-1:0];
                    uffv_pkg::REG_MAX_FILE: r_max_file <= pwdata[uffv_pkg::FILE_W-1:0];
                    default: ;
                endcase
            end

            if (in_free) begin
                r_in_vld <= i_valid;
            end

            if (out_free) begin
                r_out_vld <= proc_go && r_in_last;
            end

            if (proc_go) begin
                if (r_in_last) begin
                    // start the next file from scratch
                    r_count   <= '0;
                    r_phase   <= PH_HEAD;
                    r_head    <= '0;
                    r_shift   <= '0;
                    r_body    <= '0;
                    r_parts   <= '0;
                    r_kind    <= uffv_pkg::FMT_INVALID;
                    r_decl_lo <= '0;
                    r_decl_hi <= 1'b0;
                    r_failed  <= 1'b0;
                end else begin
                    r_count   <= n_count;
                    r_phase   <= n_phase;
                    r_head    <= n_head;
                    r_shift   <= n_shift;
                    r_body    <= n_body;
                    r_parts   <= n_parts;
                    r_kind    <= n_kind;
                    r_decl_lo <= n_decl_lo;
                    r_decl_hi <= n_decl_hi;
                    r_failed  <= n_failed;
                end
            end
        end

        if (in_free && i_valid) begin
            r_in_byte <= i_data_byte;
            r_in_last <= i_last;
        end

        if (proc_go && r_in_last) begin
            r_out_res <= n_out_res;
            r_out_fmt <= n_out_fmt;
        end
    end

    a_rose_after_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_vld) |-> $past(r_in_vld && r_in_last))
        else $error("verdict without a last word");

    a_invalid_fmt: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_vld && !r_out_res) |-> (r_out_fmt == uffv_pkg::FMT_INVALID))
        else $error("invalid verdict carries a format");

    a_file_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc_go && r_in_last) |=> (r_count == '0 && r_phase == PH_HEAD && !r_failed))
        else $error("file state not cleared after last word");

    a_body_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_BODY) |-> (r_body != '0))
        else $error("body phase with nothing left");

    a_parts_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_LEN) |-> (r_parts != '0))
        else $error("length phase with no component left");

endmodule

@@ tb/sv/user_file_format_validator_tb.sv @@
`timescale 1ns / 1ps

module user_file_format_validator_tb;

    localparam int CLK_HALF         = 10;
    localparam int RESET_CYCLES     = 11;
    localparam int CYCLE_LIMIT      = 400000;
    localparam int DRAIN_CYCLES     = 8;
    localparam int HOLD_CYCLES      = 400;
    localparam int RUN_WORDS        = 1750;
    localparam int MIN_RANDOM_FILES = 3;
    localparam int BODY_CAP         = 64;
    localparam int MAX_PRINTS       = 100;

    localparam int COMP_W  = uffv_pkg::COMP_W;
    localparam int FILE_W  = uffv_pkg::FILE_W;
    localparam int COUNT_W = uffv_pkg::COUNT_BITS_DEF;

    localparam logic [COMP_W-1:0] COMP_HIGH = COMP_W'(64 * 1024 * 1024);
    localparam logic [FILE_W-1:0] FILE_HIGH = FILE_W'(128 * 1024 * 1024);

    typedef enum logic [2:0] {
        PH_HEADER, PH_V5_HEADER, PH_LENGTH, PH_BODY, PH_DONE
    } t_phase;

    typedef enum int {
        GEN_V1, GEN_V2, GEN_V3, GEN_V4, GEN_V5, GEN_NOISE
    } t_gen_kind;

    typedef enum int {
        FLAW_NONE, FLAW_TRUNCATE, FLAW_TRAILING, FLAW_ZERO_LEN, FLAW_OVER_LEN,
        FLAW_BAD_VERSION, FLAW_BAD_TOTAL, FLAW_BAD_COUNT
    } t_flaw;

    typedef struct {
        logic [7:0] data;
        logic       last;
        int         gap;
    } t_word;

    typedef struct {
        logic       valid_res;
        logic [2:0] format;
    } t_verdict;

    logic        i_clk       = 1'b0;
    logic        i_rst_n     = 1'b0;
    logic        i_valid     = 1'b0;
    logic [7:0]  i_data_byte = 8'h00;
    logic        i_last      = 1'b0;
    logic        i_stall     = 1'b0;
    logic        psel        = 1'b0;
    logic        penable     = 1'b0;
    logic        pwrite      = 1'b0;
    logic [2:0]  paddr       = 3'd0;
    logic [31:0] pwdata      = 32'd0;
    logic        o_stall;
    logic        o_valid;
    logic        o_valid_res;
    logic [2:0]  o_format;
    logic [31:0] prdata;
    logic        pready;

    user_file_format_validator uut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_data_byte (i_data_byte),
        .i_last      (i_last),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .o_valid_res (o_valid_res),
        .o_format    (o_format),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // Parser shadow state
    logic [COUNT_W-1:0] seen_bytes;
    t_phase             phase;
    logic [63:0]        field_acc;
    int unsigned        field_pos;
    logic [31:0]        body_left;
    int unsigned        parts_to_go;
    logic [2:0]         layout;
    logic [63:0]        total_field;
    logic               file_bad;
    logic [COMP_W-1:0]  comp_limit = uffv_pkg::MAX_COMP_RESET;
    logic [FILE_W-1:0]  file_limit = uffv_pkg::MAX_FILE_RESET;

    t_word      word_q[$];
    t_verdict   verdict_q[$];
    logic [7:0] file_buf[$];

    int errors          = 0;
    int cycles          = 0;
    int words_sent      = 0;
    int files_queued    = 0;
    int verdicts_seen   = 0;
    int settings_used   = 1;
    int hold_requests   = 0;
    int holds_served    = 0;
    int tx_wait         = 0;
    int rx_wait         = 0;
    int len_hi          = 4;
    int first_len       = -1;
    int verdict_by_fmt[6];
    bit rx_free         = 1'b0;
    bit tx_quiet        = 1'b0;
    bit rx_quiet        = 1'b0;

    initial begin
        forever #CLK_HALF i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("timeout after %0d cycles, %0d verdicts pending", cycles, verdict_q.size());
            $display("** user_file_format_validator: FAILED **");
            $finish;
        end
    end

    task automatic flag_mismatch(input string msg);
        errors++;
        if (errors <= MAX_PRINTS)
            $display("ERROR @%0t: %s", $time, msg);
    endtask

    task automatic clear_tracker();
        seen_bytes  = '0;
        phase       = PH_HEADER;
        field_acc   = '0;
        field_pos   = 0;
        body_left   = '0;
        parts_to_go = 0;
        layout      = uffv_pkg::FMT_INVALID;
        total_field = '0;
        file_bad    = 1'b0;
    endtask

    task automatic accept_length(input logic [63:0] len);
        if (len == 64'd0 || len > 64'(comp_limit)) begin
            file_bad = 1'b1;
        end else begin
            body_left = len[31:0];
            phase     = PH_BODY;
        end
    endtask

    task automatic begin_lengths(input logic [2:0] fmt, input int unsigned parts);
        layout      = fmt;
        parts_to_go = parts;
        field_acc   = field_acc >> 32;
        field_pos   = uffv_pkg::SH_HALF;
        phase       = PH_LENGTH;
    endtask

    task automatic parse_word(input logic [7:0] b, input logic [COUNT_W-1:0] pos);
        case (phase)
            PH_HEADER: begin
                field_acc |= 64'(b) << (8 * pos[2:0]);
                if (pos[2:0] == uffv_pkg::HEAD_LAST) begin
                    if (field_acc == uffv_pkg::V5_MAGIC_LE) begin
                        layout    = uffv_pkg::FMT_V5;
                        field_acc = '0;
                        field_pos = 0;
                        phase     = PH_V5_HEADER;
                    end else if (field_acc[31:0] == uffv_pkg::VER_V3) begin
                        begin_lengths(uffv_pkg::FMT_V3, uffv_pkg::PARTS_9);
                    end else if (field_acc[31:0] == uffv_pkg::VER_V4) begin
                        begin_lengths(uffv_pkg::FMT_V4, uffv_pkg::PARTS_9);
                    end else if (field_acc[31:0] == uffv_pkg::VER_V2) begin
                        begin_lengths(uffv_pkg::FMT_V2, uffv_pkg::PARTS_7);
                    end else begin
                        // no version word: the first eight bytes are already a length
                        layout      = uffv_pkg::FMT_V1;
                        parts_to_go = uffv_pkg::PARTS_4;
                        accept_length(field_acc);
                    end
                end
            end
            PH_V5_HEADER: begin
                field_acc = {field_acc[55:0], b};
                field_pos++;
                if (field_pos == uffv_pkg::SH_VER_END) begin
                    if (field_acc != 64'(uffv_pkg::V5_VERSION))
                        file_bad = 1'b1;
                    field_acc = '0;
                end else if (field_pos == uffv_pkg::SH_TOTAL_END) begin
                    total_field = field_acc;
                    field_acc   = '0;
                end else if (field_pos >= uffv_pkg::SH_HDR_END) begin
                    if (field_acc != 64'(uffv_pkg::V5_COUNT))
                        file_bad = 1'b1;
                    field_acc   = '0;
                    field_pos   = 0;
                    parts_to_go = uffv_pkg::PARTS_9;
                    phase       = PH_LENGTH;
                end
            end
            PH_LENGTH: begin
                if (layout == uffv_pkg::FMT_V5)
                    field_acc = {field_acc[55:0], b};
                else
                    field_acc |= 64'(b) << (8 * (field_pos % 8));
                field_pos++;
                if (field_pos >= uffv_pkg::SH_LEN_END)
                    accept_length(field_acc);
            end
            PH_BODY: begin
                if (body_left > 0)
                    body_left--;
                if (body_left == 0) begin
                    if (parts_to_go > 0)
                        parts_to_go--;
                    if (parts_to_go == 0) begin
                        phase = PH_DONE;
                    end else begin
                        field_acc = '0;
                        field_pos = 0;
                        phase     = PH_LENGTH;
                    end
                end
            end
            default: file_bad = 1'b1;  // anything past the last body
        endcase
    endtask

    task automatic track_byte(input logic [7:0] b, input logic last);
        logic [COUNT_W-1:0] pos;
        t_verdict           v;
        logic               ok;
        pos = seen_bytes;
        if (seen_bytes == '1)
            file_bad = 1'b1;
        else
            seen_bytes++;
        if (64'(seen_bytes) > 64'(file_limit))
            file_bad = 1'b1;
        if (!file_bad)
            parse_word(b, pos);
        if (last) begin
            ok = !file_bad && phase == PH_DONE &&
                 (layout != uffv_pkg::FMT_V5 || total_field == 64'(seen_bytes));
            v.valid_res = ok;
            v.format    = ok ? layout : uffv_pkg::FMT_INVALID;
            verdict_q.push_back(v);
            verdict_by_fmt[v.format]++;
            clear_tracker();
        end
    endtask

    task automatic check_verdict(input logic got_valid, input logic [2:0] got_fmt);
        t_verdict want;
        if (verdict_q.size() == 0) begin
            flag_mismatch($sformatf("verdict valid_res=%0b format=%0d with none pending",
                                    got_valid, got_fmt));
            return;
        end
        want = verdict_q.pop_front();
        verdicts_seen++;
        if (got_valid !== want.valid_res)
            flag_mismatch($sformatf("verdict %0d: valid_res %0b, want %0b",
                                    verdicts_seen, got_valid, want.valid_res));
        if (got_fmt !== want.format)
            flag_mismatch($sformatf("verdict %0d: format %0d, want %0d",
                                    verdicts_seen, got_fmt, want.format));
    endtask

    // Byte driver
    always @(posedge i_clk) begin
        t_word w;
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_wait = 0;
            clear_tracker();
        end else begin
            if (i_valid && !o_stall) begin
                track_byte(i_data_byte, i_last);
                words_sent++;
            end
            if (!i_valid || !o_stall) begin
                if (tx_wait > 0) begin
                    tx_wait--;
                    i_valid <= 1'b0;
                end else if (word_q.size() > 0) begin
                    w = word_q.pop_front();
                    i_valid     <= 1'b1;
                    i_data_byte <= w.data;
                    i_last      <= w.last;
                    tx_wait = w.gap;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Verdict monitor and receiver stall
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_stall <= 1'b0;
            rx_wait = 0;
        end else begin
            if (o_valid && !i_stall) begin
                check_verdict(o_valid_res, o_format);
                rx_wait = rx_quiet ? 0 : $urandom_range(0, 3);
                rx_free = $urandom_range(0, 1);
            end else if (rx_wait > 0 && (o_valid || rx_free)) begin
                rx_wait--;
            end
            if (holds_served < hold_requests) begin
                holds_served++;
                rx_wait = HOLD_CYCLES;
                rx_free = 1'b1;
            end
            i_stall <= (rx_wait > 0);
        end
    end

    task automatic wait_idle();
        while (word_q.size() != 0 || i_valid || verdict_q.size() != 0 ||
               verdicts_seen < files_queued)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_write(input logic idx, input logic [31:0] val);
        @(posedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= val;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_limits(input logic [COMP_W-1:0] comp, input logic [FILE_W-1:0] fsize);
        wait_idle();
        apb_write(uffv_pkg::REG_MAX_COMP, 32'(comp));
        apb_write(uffv_pkg::REG_MAX_FILE, 32'(fsize));
        comp_limit = comp;
        file_limit = fsize;
        settings_used++;
    endtask

    task automatic put_le(input logic [63:0] v, input int n);
        for (int i = 0; i < n; i++)
            file_buf.push_back(v[8*i +: 8]);
    endtask

    task automatic put_be(input logic [63:0] v, input int n);
        for (int i = n - 1; i >= 0; i--)
            file_buf.push_back(v[8*i +: 8]);
    endtask

    task automatic put_body(input int n);
        repeat (n) file_buf.push_back(8'($urandom));
    endtask

    task automatic make_file(input t_gen_kind kind, input t_flaw flaw);
        int          parts;
        int          bad_part;
        logic [63:0] len;
        logic [63:0] total;
        file_buf.delete();
        if (kind == GEN_NOISE) begin
            put_body($urandom_range(1, 24));
            return;
        end
        parts    = (kind == GEN_V1) ? uffv_pkg::PARTS_4 :
                   (kind == GEN_V2) ? uffv_pkg::PARTS_7 : uffv_pkg::PARTS_9;
        bad_part = $urandom_range(0, parts - 1);
        case (kind)
            GEN_V5: begin
                put_le(uffv_pkg::V5_MAGIC_LE, 8);
                if (flaw == FLAW_BAD_VERSION)
                    put_be(64'(uffv_pkg::V5_VERSION ^ (32'd1 << $urandom_range(0, 31))), 4);
                else
                    put_be(64'(uffv_pkg::V5_VERSION), 4);
                put_be(64'd0, 8);
                if (flaw == FLAW_BAD_COUNT)
                    put_be(64'(uffv_pkg::V5_COUNT ^ (32'd1 << $urandom_range(0, 31))), 4);
                else
                    put_be(64'(uffv_pkg::V5_COUNT), 4);
            end
            GEN_V2:  put_le(64'(uffv_pkg::VER_V2), 4);
            GEN_V3:  put_le(64'(uffv_pkg::VER_V3), 4);
            GEN_V4:  put_le(64'(uffv_pkg::VER_V4), 4);
            default: ;
        endcase
        for (int p = 0; p < parts; p++) begin
            len = (p == 0 && first_len > 0) ? 64'(first_len) : 64'($urandom_range(1, len_hi));
            // keep a V1 first length from reading as a version word
            if (kind == GEN_V1 && p == 0 && len >= 2 && len <= 4)
                len = len + 3;
            if (flaw == FLAW_ZERO_LEN && p == bad_part)
                len = 64'd0;
            if (flaw == FLAW_OVER_LEN && p == bad_part) begin
                if ($urandom_range(0, 1))
                    len = 64'(comp_limit) + 64'd1 + 64'($urandom_range(0, 5));
                else
                    len = {32'($urandom) | 32'h8000_0000, 32'($urandom)};
            end
            if (kind == GEN_V5)
                put_be(len, 8);
            else
                put_le(len, 8);
            put_body((len <= BODY_CAP) ? int'(len) : $urandom_range(0, 3));
        end
        if (kind == GEN_V5) begin
            total = 64'(file_buf.size());
            if (flaw == FLAW_BAD_TOTAL)
                total = $urandom_range(0, 1) ? total + 64'd1 : total - 64'd1;
            for (int i = 0; i < 8; i++)
                file_buf[12 + i] = total[8*(7 - i) +: 8];
        end
        if (flaw == FLAW_TRUNCATE) begin
            int keep;
            keep = $urandom_range(1, file_buf.size() - 1);
            while (file_buf.size() > keep)
                void'(file_buf.pop_back());
        end
        if (flaw == FLAW_TRAILING)
            put_body($urandom_range(1, 3));
    endtask

    task automatic send_file();
        t_word w;
        for (int i = 0; i < file_buf.size(); i++) begin
            w.data = file_buf[i];
            w.last = (i == file_buf.size() - 1);
            w.gap  = tx_quiet ? 0 : $urandom_range(0, 3);
            word_q.push_back(w);
        end
        files_queued++;
    endtask

    task automatic send_bytes(input logic [63:0] v, input int n);
        file_buf.delete();
        put_le(v, n);
        send_file();
    endtask

    task automatic random_file();
        t_gen_kind kind;
        t_flaw     flaw;
        int        r;
        r    = $urandom_range(0, 99);
        kind = (r < 15) ? GEN_NOISE : t_gen_kind'($urandom_range(GEN_V1, GEN_V5));
        r    = $urandom_range(0, 99);
        flaw = (r < 65) ? FLAW_NONE : t_flaw'($urandom_range(FLAW_TRUNCATE, FLAW_BAD_COUNT));
        // throttle so idle modes track the files being sent
        while (word_q.size() > 64)
            @(posedge i_clk);
        tx_quiet = ($urandom_range(0, 4) == 0);
        rx_quiet = ($urandom_range(0, 4) == 0);
        make_file(kind, flaw);
        send_file();
    endtask

    initial begin
        int file_size;
        int start_files;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // short files, all-zero and all-one bytes, zero first length, cut-off V5 header
        send_bytes(64'h00, 1);
        send_bytes(64'hFF, 1);
        send_bytes(64'h0, 8);
        file_buf.delete();
        put_le(uffv_pkg::V5_MAGIC_LE, 8);
        put_body(1);
        send_file();
        send_bytes(64'hFFFF_FFFF_FFFF_FFFF, 8);

        // one clean file of each layout at the shortest bodies
        len_hi = 1;
        for (int k = GEN_V1; k <= GEN_V5; k++) begin
            make_file(t_gen_kind'(k), FLAW_NONE);
            send_file();
        end
        len_hi = 4;

        repeat (4) random_file();

        // tightest component limit, widest file limit
        set_limits(COMP_W'(1), FILE_HIGH);
        len_hi = 2;
        repeat (3) random_file();

        // widest component limit, one-byte file limit
        set_limits(COMP_HIGH, FILE_W'(1));
        send_bytes(64'h5A, 1);
        repeat (2) random_file();

        // component length right at and one past the limit
        set_limits(COMP_W'(6), FILE_HIGH);
        len_hi     = 1;
        first_len  = 6;
        make_file(GEN_V1, FLAW_NONE);
        send_file();
        first_len  = 7;
        make_file(GEN_V1, FLAW_NONE);
        send_file();
        first_len  = -1;

        // file size right at and one past the limit
        len_hi = 3;
        make_file(GEN_V2, FLAW_NONE);
        file_size = file_buf.size();
        set_limits(COMP_W'(6), FILE_W'(file_size));
        send_file();
        set_limits(COMP_W'(6), FILE_W'(file_size - 1));
        send_file();

        // hold the result side off while short files pile up behind it
        set_limits(uffv_pkg::MAX_COMP_RESET, uffv_pkg::MAX_FILE_RESET);
        tx_quiet = 1'b1;
        rx_quiet = 1'b1;
        hold_requests++;
        len_hi = 1;
        for (int i = 0; i < 20; i++) begin
            if (i % 10 == 9)
                make_file(GEN_V1, FLAW_NONE);
            else
                make_file(GEN_NOISE, FLAW_NONE);
            send_file();
        end

        len_hi      = 4;
        start_files = files_queued;
        while (words_sent + word_q.size() < RUN_WORDS ||
               files_queued - start_files < MIN_RANDOM_FILES) begin
            if ($urandom_range(0, 19) == 0)
                len_hi = $urandom_range(1, 12);
            random_file();
        end

        wait_idle();
        if (verdict_q.size() != 0)
            flag_mismatch($sformatf("%0d verdicts never arrived", verdict_q.size()));

        $display("run: %0d bytes in %0d files, %0d verdicts checked, %0d limit settings",
                 words_sent, files_queued, verdicts_seen, settings_used);
        $display("valid V1..V5: %0d %0d %0d %0d %0d, invalid: %0d, long holds: %0d",
                 verdict_by_fmt[uffv_pkg::FMT_V1], verdict_by_fmt[uffv_pkg::FMT_V2],
                 verdict_by_fmt[uffv_pkg::FMT_V3], verdict_by_fmt[uffv_pkg::FMT_V4],
                 verdict_by_fmt[uffv_pkg::FMT_V5], verdict_by_fmt[uffv_pkg::FMT_INVALID],
                 holds_served);
        if (errors == 0) begin
            $display("** user_file_format_validator: PASSED **");
        end else begin
            $display("** user_file_format_validator: FAILED **");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
src/uffv_pkg.sv
src/user_file_format_validator.sv
tb/sv/user_file_format_validator_tb.sv
